### sv/autoranging_frequency_meter_assert.svh
// ----------------------------------------------------------------------------
// Frequency meter assertion macros
// Concurrent assertion macros shared by the checker of the frequency meter.
// ----------------------------------------------------------------------------
`ifndef AUTORANGING_FREQUENCY_METER_ASSERT_SVH
`define AUTORANGING_FREQUENCY_METER_ASSERT_SVH

// The condition must hold in the same cycle as its trigger.
`define AFM_ASSERT_NOW(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("%m: frequency meter check failed");

// The condition must hold in the cycle after its trigger.
`define AFM_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("%m: frequency meter check failed");

`endif

### sv/afm_pkg.sv
// ----------------------------------------------------------------------------
// Frequency meter package
// Shared types, sequencer states and constants of the autoranging meter.
// ----------------------------------------------------------------------------
package afm_pkg;

	localparam int QBITS = 21;
	localparam int DIV_W = 29;

	localparam logic        CMD_CAPTURE   = 1'b0;
	localparam logic        CMD_OVERFLOW  = 1'b1;
	localparam logic        REG_TIMER_CLK = 1'b0;

	localparam logic [17:0] PERIOD_INIT   = 18'h2000;
	localparam logic [17:0] SHIFT_LOW     = 18'h1000;
	localparam logic [17:0] SHIFT_HIGH    = 18'h4000;
	localparam logic [3:0]  EXP_MAX       = 4'd13;
	localparam logic [13:0] PRESCALE_MAX  = 14'd8192;
	localparam logic [2:0]  MISSING_LIMIT = 3'd4;
	localparam logic [28:0] CLK_RESET     = 29'd100000000;
	localparam logic [3:0]  FREQ_LOW_HZ   = 4'd10;
	localparam logic [12:0] FREQ_HIGH_HZ  = 13'd5000;
	localparam logic [15:0] RECIP5        = 16'hCCCD;
	localparam logic [4:0]  DIV_STEPS     = 5'd21;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_OVF,
		ST_RANGE,
		ST_WIN,
		ST_BAND_LO,
		ST_BAND_HI,
		ST_DIV,
		ST_FFILT,
		ST_ERPM1,
		ST_ERPM2,
		ST_DONE
	} afm_state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] clk_hz;
		logic [DIV_W-1:0] divisor;
	} afm_div_req_t;

	typedef struct packed {
		logic             done;
		logic [QBITS-1:0] quotient;
	} afm_div_rsp_t;

endpackage

### sv/autoranging_frequency_meter.sv
// ----------------------------------------------------------------------------
// Autoranging frequency meter
// Turns timer capture and overflow events into a filtered frequency and
// steers the timer prescaler to keep the measured period in range.
// ----------------------------------------------------------------------------
// Each input word is one timer event: cmd 0 is a capture edge with its counter
// value, cmd 1 a timer overflow. Every word yields exactly one result word
// with the filtered frequency, its eRPM/100 value, the prescaler ratio and
// the reload and reset flags.
// An overflow or a first edge goes straight to the eRPM states; a measured
// edge passes the range, window and band checks and then the divider, one bit
// per cycle, that forms clock*256/(prescaler*period); an edge rejected by the
// window or band checks skips the divider. The input is not ready while a word
// is in progress and becomes ready in the cycle after the result is written.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a stalled receiver only holds the block once the
// next result is ready to be written.
// Reset clears the filters, the prescaler returns to 8192 and the timer clock
// register to 100 MHz. The register is written through the APB port at
// address 0 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module autoranging_frequency_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] capture_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] freq_q8,
	output logic [11:0] erpm_div100,
	output logic [13:0] prescale_div,
	output logic        timer_reload,
	output logic        was_reset
);
	import afm_pkg::*;

	afm_state_t   state_q, state_d;
	afm_div_req_t div_req;
	afm_div_rsp_t div_rsp;

	logic [28:0] clk_hz_q;
	logic [17:0] avg_period_q;
	logic [15:0] last_capture_q;
	logic [20:0] avg_freq_q;
	logic [3:0]  exp_q;
	logic        overflow_q;
	logic [2:0]  missing_q;
	logic        cmd_q;
	logic [15:0] cap_q;
	logic [15:0] p_q;
	logic [28:0] d_q;
	logic        reload_q;
	logic        did_reset_q;
	logic [13:0] t_q;
	logic [11:0] erpm_q;
	logic        out_valid_q;

	logic        accept;
	logic        out_free;
	logic [15:0] p_now;
	logic [18:0] pdiff;
	logic [18:0] pstep;
	logic [19:0] avg3;
	logic        in_window;
	logic [32:0] d10;
	logic [41:0] d5000;
	logic [21:0] fdiff;
	logic [21:0] fstep;
	logic [21:0] f3;
	logic [29:0] erpm_prod;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMER_CLK) ? {3'd0, clk_hz_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TIMER_CLK) begin
			clk_hz_q <= pwdata[28:0];
		end
	end

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign p_now = cap_q - last_capture_q;
	assign pdiff = {3'd0, p_now} - {1'b0, avg_period_q};
	assign pstep = (pdiff[18] && pdiff[4:0] != 5'd0)
		? {{5{pdiff[18]}}, pdiff[18:5]} + 19'd1 : {{5{pdiff[18]}}, pdiff[18:5]};

	assign avg3      = {2'd0, avg_period_q} + {1'b0, avg_period_q, 1'b0};
	assign in_window = ({4'd0, p_q} > {2'd0, avg3[19:2]}) && ({3'd0, p_q} < avg3[19:1])
		&& (p_q != 16'd0);

	assign d10   = d_q * FREQ_LOW_HZ;
	assign d5000 = d_q * FREQ_HIGH_HZ;

	assign fdiff = {1'b0, div_rsp.quotient} - {1'b0, avg_freq_q};
	assign fstep = (fdiff[21] && fdiff[2:0] != 3'd0)
		? {{3{fdiff[21]}}, fdiff[21:3]} + 22'd1 : {{3{fdiff[21]}}, fdiff[21:3]};

	assign f3        = {1'b0, avg_freq_q} + {avg_freq_q, 1'b0};
	assign erpm_prod = t_q * RECIP5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		div_req.start   = 1'b0;
		div_req.clk_hz  = clk_hz_q;
		div_req.divisor = d_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (cmd == CMD_OVERFLOW) ? ST_OVF : ST_EDGE;
				end
			end
			ST_EDGE: begin
				state_d = (last_capture_q != 16'd0) ? ST_RANGE : ST_ERPM1;
			end
			ST_OVF:   state_d = ST_ERPM1;
			ST_RANGE: state_d = ST_WIN;
			ST_WIN:   state_d = in_window ? ST_BAND_LO : ST_ERPM1;
			ST_BAND_LO: begin
				state_d = ({4'd0, clk_hz_q} > d10) ? ST_BAND_HI : ST_ERPM1;
			end
			ST_BAND_HI: begin
				if ({13'd0, clk_hz_q} < d5000) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_ERPM1;
				end
			end
			ST_DIV:   state_d = div_rsp.done ? ST_FFILT : ST_DIV;
			ST_FFILT: state_d = ST_ERPM1;
			ST_ERPM1: state_d = ST_ERPM2;
			ST_ERPM2: state_d = ST_DONE;
			ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_period_q   <= PERIOD_INIT;
			last_capture_q <= '0;
			avg_freq_q     <= '0;
			exp_q          <= EXP_MAX;
			overflow_q     <= 1'b0;
			missing_q      <= '0;
			reload_q       <= 1'b0;
			did_reset_q    <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						reload_q    <= 1'b0;
						did_reset_q <= 1'b0;
					end
				end
				ST_EDGE: begin
					if (last_capture_q != 16'd0) begin
						avg_period_q <= 18'(avg_period_q + pstep[17:0]);
					end
					last_capture_q <= cap_q;
					overflow_q     <= 1'b0;
					missing_q      <= '0;
				end
				ST_OVF: begin
					overflow_q <= !overflow_q;
					if (overflow_q) begin
						last_capture_q <= '0;
						if (missing_q >= MISSING_LIMIT) begin
							avg_period_q <= PERIOD_INIT;
							avg_freq_q   <= '0;
							exp_q        <= EXP_MAX;
							missing_q    <= '0;
							reload_q     <= 1'b1;
							did_reset_q  <= 1'b1;
						end else begin
							missing_q <= missing_q + 3'd1;
						end
					end
				end
				ST_RANGE: begin
					if (avg_period_q < SHIFT_LOW && exp_q != 4'd0) begin
						exp_q        <= exp_q - 4'd1;
						avg_period_q <= {avg_period_q[16:0], 1'b0};
						reload_q     <= 1'b1;
					end else if (avg_period_q > SHIFT_HIGH && exp_q != EXP_MAX) begin
						exp_q        <= exp_q + 4'd1;
						avg_period_q <= avg_period_q >> 1;
						reload_q     <= 1'b1;
					end
				end
				ST_FFILT: begin
					avg_freq_q <= 21'(avg_freq_q + fstep[20:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			cap_q <= capture_value;
		end
		if (state_q == ST_EDGE) begin
			p_q <= p_now;
		end
		if (state_q == ST_RANGE) begin
			if (avg_period_q < SHIFT_LOW && exp_q != 4'd0) begin
				p_q <= {p_q[14:0], 1'b0};
			end else if (avg_period_q > SHIFT_HIGH && exp_q != EXP_MAX) begin
				p_q <= p_q >> 1;
			end
		end
		if (state_q == ST_WIN) begin
			d_q <= 29'({13'd0, p_q} << exp_q);
		end
		if (state_q == ST_ERPM1) begin
			t_q <= f3[21:8];
		end
		if (state_q == ST_ERPM2) begin
			erpm_q <= erpm_prod[29:18];
		end
		if (state_q == ST_DONE && out_free) begin
			freq_q8      <= avg_freq_q;
			erpm_div100  <= erpm_q;
			prescale_div <= 14'(14'd1 << exp_q);
			timer_reload <= reload_q;
			was_reset    <= did_reset_q && (cmd_q == CMD_OVERFLOW);
		end
	end

	assign out_valid = out_valid_q;

	afm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### sv/afm_div.sv
// ----------------------------------------------------------------------------
// Frequency divider
// Restoring divider giving floor(clock * 256 / divisor), one quotient bit per
// cycle, each bit from one compare-and-subtract step.
// ----------------------------------------------------------------------------
module afm_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  afm_pkg::afm_div_req_t req,
	output afm_pkg::afm_div_rsp_t rsp
);
	import afm_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [QBITS-1:0] num_q;
	logic [DIV_W-1:0] divisor_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[QBITS-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= DIV_STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= {13'd0, req.clk_hz[DIV_W-1:13]};
			num_q     <= {req.clk_hz[12:0], 8'd0};
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
			num_q <= {num_q[QBITS-2:0], fits};
		end
	end

	assign rsp = {done_q, num_q};

endmodule

### sv/afm_checker.sv
// ----------------------------------------------------------------------------
// Frequency meter checker
// Port-level assertions of the autoranging frequency meter, bound to its top.
// ----------------------------------------------------------------------------
`include "autoranging_frequency_meter_assert.svh"

module afm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [20:0] freq_q8,
	input logic [11:0] erpm_div100,
	input logic [13:0] prescale_div,
	input logic        timer_reload,
	input logic        was_reset
);
	import afm_pkg::*;

	`AFM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`AFM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(freq_q8))
	`AFM_ASSERT_NOW(a_prescale_pow2, out_valid, $onehot(prescale_div))
	`AFM_ASSERT_NOW(a_reset_result, out_valid && was_reset, timer_reload && freq_q8 == 21'd0 && erpm_div100 == 12'd0 && prescale_div == PRESCALE_MAX)

endmodule

bind autoranging_frequency_meter afm_checker u_afm_checker (.*);

### bench/tb_autoranging_frequency_meter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Autoranging frequency meter testbench
// Drives capture and overflow words that mimic a prescaled timer watching a
// signal, tracks the expected filtered frequency, prescaler and flags in a
// scoreboard of its own, and checks every result word as it is taken.
// ----------------------------------------------------------------------------
module tb_autoranging_frequency_meter;
	import afm_pkg::*;

	localparam logic [2:0]  ADDR_TIMER_CLK = {REG_TIMER_CLK, 2'b00};
	localparam logic [31:0] CLK_MASK       = 32'h1FFF_FFFF;
	localparam logic [31:0] STRAY_BITS     = 32'hE000_0000;
	localparam int          RANGE_LOW      = SHIFT_LOW;
	localparam int          RANGE_HIGH     = SHIFT_HIGH;
	localparam int          PRESCALE_TOP   = PRESCALE_MAX;
	localparam int          PERIOD_STEPS   = 32;
	localparam int          FREQ_STEPS     = 8;
	localparam int          MISSING_TOP    = MISSING_LIMIT;
	localparam int          ERPM_NUM       = 60;
	localparam int          ERPM_DEN       = 25600;

	typedef struct packed {
		logic [20:0] freq;
		logic [11:0] erpm;
		logic [13:0] presc;
		logic        reload;
		logic        dead;
	} reading_t;

	class freq_meter_board;
		int unsigned clock_hz;
		int          avg_period;
		logic [15:0] last_capture;
		longint      avg_freq;
		int          prescale;
		int          ovf_count;
		int          miss_count;
		reading_t    pending_readings[$];
		int          errors;
		int          readings_checked;
		int          freq_updates;
		int          range_steps;
		int          dead_resets;

		function new();
			clock_hz = CLK_RESET;
			clear_state();
			errors = 0;
			readings_checked = 0;
			freq_updates = 0;
			range_steps = 0;
			dead_resets = 0;
		endfunction

		function void clear_state();
			avg_period = PERIOD_INIT;
			last_capture = 0;
			avg_freq = 0;
			prescale = PRESCALE_TOP;
			ovf_count = 0;
			miss_count = 0;
		endfunction

		function bit measure_period(logic [15:0] raw);
			int     p;
			int     lo;
			int     hi;
			longint d;
			longint clk_l;
			longint f;
			bit     stepped;
			stepped = 0;
			p = raw;
			avg_period = avg_period + (p - avg_period) / PERIOD_STEPS;
			if (avg_period < RANGE_LOW && prescale > 1) begin
				prescale = prescale >> 1;
				avg_period = avg_period * 2;
				p = (p << 1) & 16'hFFFF;
				stepped = 1;
			end else if (avg_period > RANGE_HIGH && prescale < PRESCALE_TOP) begin
				prescale = prescale << 1;
				avg_period = avg_period / 2;
				p = p >> 1;
				stepped = 1;
			end
			lo = (avg_period * 3) / 4;
			hi = (avg_period * 3) / 2;
			if (p > lo && p < hi && p != 0) begin
				d = longint'(prescale) * p;
				clk_l = clock_hz;
				if (clk_l > longint'(FREQ_LOW_HZ) * d && clk_l < longint'(FREQ_HIGH_HZ) * d) begin
					f = (clk_l << 8) / d;
					avg_freq = avg_freq + (f - avg_freq) / FREQ_STEPS;
					freq_updates++;
				end
			end
			if (stepped)
				range_steps++;
			return stepped;
		endfunction

		function void note_event(logic c, logic [15:0] v);
			bit       reload;
			bit       dead;
			longint   erpm;
			reading_t r;
			reload = 0;
			dead = 0;
			if (c == CMD_CAPTURE) begin
				if (last_capture != 0)
					reload = measure_period(v - last_capture);
				last_capture = v;
				ovf_count = 0;
				miss_count = 0;
			end else begin
				ovf_count++;
				if (ovf_count > 1) begin
					miss_count++;
					if (miss_count > MISSING_TOP) begin
						clear_state();
						reload = 1;
						dead = 1;
						dead_resets++;
					end
					ovf_count = 0;
					last_capture = 0;
				end
			end
			erpm = (avg_freq * ERPM_NUM) / ERPM_DEN;
			r.freq = avg_freq[20:0];
			r.erpm = erpm[11:0];
			r.presc = prescale[13:0];
			r.reload = reload;
			r.dead = dead;
			pending_readings.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				errors++;
				$display("%0t: result word arrived with nothing expected", $time);
				return;
			end
			want = pending_readings.pop_front();
			readings_checked++;
			compare_field("freq_q8", want.freq, got.freq);
			compare_field("erpm_div100", want.erpm, got.erpm);
			compare_field("prescale_div", want.presc, got.presc);
			compare_field("timer_reload", want.reload, got.reload);
			compare_field("was_reset", want.dead, got.dead);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [15:0] capture_value;
	logic        out_valid;
	logic        out_ready;
	logic [20:0] freq_q8;
	logic [11:0] erpm_div100;
	logic [13:0] prescale_div;
	logic        timer_reload;
	logic        was_reset;

	freq_meter_board board;
	bit              calm;
	int              words_sent;
	logic [15:0]     tmr_count;

	autoranging_frequency_meter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.capture_value(capture_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.freq_q8      (freq_q8),
		.erpm_div100  (erpm_div100),
		.prescale_div (prescale_div),
		.timer_reload (timer_reload),
		.was_reset    (was_reset)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_word(input logic c, input logic [15:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		capture_value <= v;
		do @(posedge clk); while (!in_ready);
		board.note_event(c, v);
		words_sent++;
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_timer_clock(input logic [31:0] value);
		logic [31:0] rdata;
		in_valid <= 1'b0;
		while (board.pending_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		apb_access(1'b1, ADDR_TIMER_CLK, value, rdata);
		board.clock_hz = value & CLK_MASK;
		@(posedge clk);
		apb_access(1'b0, ADDR_TIMER_CLK, '0, rdata);
		board.compare_field("timer_clock_hz", board.clock_hz, rdata);
	endtask

	task automatic signal_burst(input int freq_hz, input int edges);
		longint ticks;
		int     jit;
		for (int i = 0; i < edges; i++) begin
			case ($urandom_range(0, 39))
				0: send_word(CMD_OVERFLOW, 16'($urandom));
				1: send_word(CMD_CAPTURE, 16'($urandom));
				default: begin
					ticks = longint'(board.clock_hz) / (longint'(board.prescale) * freq_hz);
					jit = $urandom_range(0, 6);
					ticks = ticks + (ticks * (jit - 3)) / 100;
					if (ticks < 1)
						ticks = 1;
					tmr_count = tmr_count + ticks[15:0];
					send_word(CMD_CAPTURE, tmr_count);
				end
			endcase
		end
	endtask

	task automatic dead_signal(input int count);
		for (int i = 0; i < count; i++)
			send_word(CMD_OVERFLOW, 16'($urandom));
	endtask

	task automatic run_phase(input int budget);
		int start;
		int freq_hz;
		start = words_sent;
		while (words_sent - start < budget) begin
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: dead_signal($urandom_range(3, 12));
				1: freq_hz = $urandom_range(1, 9);
				2: freq_hz = $urandom_range(5001, 20000);
				3, 4: freq_hz = $urandom_range(10, 100);
				5, 6: freq_hz = $urandom_range(100, 1000);
				default: freq_hz = $urandom_range(1000, 5000);
			endcase
			if (freq_hz > 0)
				signal_burst(freq_hz, $urandom_range(20, 60));
			freq_hz = 0;
		end
	endtask

	initial begin
		int       gap;
		reading_t got;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.freq = freq_q8;
			got.erpm = erpm_div100;
			got.presc = prescale_div;
			got.reload = timer_reload;
			got.dead = was_reset;
			board.check_reading(got);
		end
	end

	initial begin
		logic [31:0] rdata;
		board = new();
		calm = 1'b0;
		words_sent = 0;
		tmr_count = '0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= CMD_CAPTURE;
		capture_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, ADDR_TIMER_CLK, '0, rdata);
		board.compare_field("timer_clock_hz", CLK_RESET, rdata);

		send_word(CMD_CAPTURE, 16'h0000);
		send_word(CMD_CAPTURE, 16'hFFFF);
		send_word(CMD_CAPTURE, 16'h0001);
		send_word(CMD_CAPTURE, 16'h0000);
		send_word(CMD_CAPTURE, 16'h8000);
		send_word(CMD_OVERFLOW, 16'hFFFF);
		send_word(CMD_OVERFLOW, 16'h0000);
		send_word(CMD_CAPTURE, 16'h1234);
		send_word(CMD_OVERFLOW, 16'hAAAA);
		send_word(CMD_CAPTURE, 16'h3234);
		send_word(CMD_CAPTURE, 16'h5555);
		send_word(CMD_CAPTURE, 16'h5555);
		dead_signal(10);

		set_timer_clock(STRAY_BITS | 32'($urandom_range(1000000, 400000000)));
		run_phase(160);
		set_timer_clock(32'd400000000);
		run_phase(160);
		set_timer_clock(32'd1000000);
		run_phase(160);
		set_timer_clock(32'(CLK_RESET));
		run_phase(170);

		in_valid <= 1'b0;
		while (board.pending_readings.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Summary: %0d event words sent, %0d results checked, %0d frequency updates,",
			words_sent, board.readings_checked, board.freq_updates);
		$display("%0d prescaler steps and %0d dead-signal resets, over four timer clock settings.",
			board.range_steps, board.dead_resets);
		if (board.errors == 0 && board.pending_readings.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/afm_pkg.sv
sv/afm_div.sv
sv/autoranging_frequency_meter.sv
sv/afm_checker.sv
bench/tb_autoranging_frequency_meter.sv
